[rtl/core/i2cee_pkg.sv]
// ----------------------------------------------------------------------------
// i2cee_pkg
// Shared types and constants for the 24Cxx-style I2C EEPROM slave.
// ----------------------------------------------------------------------------
package i2cee_pkg;

    localparam int unsigned MEM_BYTES_DEF   = 4096;
    localparam int unsigned IMAGE_BYTES_DEF = 4096;
    localparam int unsigned PAGE_BYTES_DEF  = 32;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // One byte event on the bus.
    typedef struct packed {
        logic       func;       // 0: master writes, 1: master reads
        logic       start_req;
        logic [7:0] data;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       ack;
    } t_out;

    // Addressing phase of the slave.
    typedef enum logic [2:0] {
        PH_IDLE      = 3'b001,
        PH_ADDR_HI   = 3'b010,
        PH_ADDR_DONE = 3'b100
    } t_phase;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_RUN    = 3'b010,
        ST_RDWAIT = 3'b100
    } t_ctl_state;

    // Controller to datapath.
    typedef struct packed {
        logic clear_wr;     // erase one memory entry
        logic take_item;    // an input beat is accepted this cycle
        logic load_mem_rd;  // move the memory read data into the result
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last;   // the erase pass is at its final entry
        logic needs_mem_rd; // the offered beat is a read of stored data
    } t_dp_stat;

endpackage

[rtl/core/i2cee_ctrl.sv]
// ----------------------------------------------------------------------------
// i2cee_ctrl
// Controller: erase pass sequencing, input acceptance and result valid.
// ----------------------------------------------------------------------------
module i2cee_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_stall,
    input  i2cee_pkg::t_dp_stat i_stat,
    output i2cee_pkg::t_dp_cmd  o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);
    import i2cee_pkg::*;

    t_ctl_state r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       take;

    assign out_free = !r_out_valid || !i_out_stall;
    assign take     = i_in_valid && (r_state == ST_RUN) && out_free;

    assign o_cmd.clear_wr    = (r_state == ST_CLEAR);
    assign o_cmd.take_item   = take;
    assign o_cmd.load_mem_rd = (r_state == ST_RDWAIT);

    assign o_in_stall  = !((r_state == ST_RUN) && out_free);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (take && i_stat.needs_mem_rd) begin
                    n_state = ST_RDWAIT;
                end
            end
            ST_RDWAIT: n_state = ST_RUN;
            default:   n_state = ST_CLEAR;
        endcase
    end

    // A result register that is free or being drained is the only one that
    // can be loaded, so a new result never overwrites a waiting one.
    always_comb begin
        priority if ((take && !i_stat.needs_mem_rd) || (r_state == ST_RDWAIT)) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/core/i2cee_dp.sv]
// ----------------------------------------------------------------------------
// i2cee_dp
// Datapath: phase and word address registers, write enable register, the
// byte memory with its erase counter, and the result register.
// ----------------------------------------------------------------------------
module i2cee_dp #(
    parameter int unsigned MEM_BYTES   = i2cee_pkg::MEM_BYTES_DEF,
    parameter int unsigned IMAGE_BYTES = i2cee_pkg::IMAGE_BYTES_DEF,
    parameter int unsigned PAGE_BYTES  = i2cee_pkg::PAGE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  i2cee_pkg::t_in      i_in,
    input  i2cee_pkg::t_dp_cmd  i_cmd,
    output i2cee_pkg::t_dp_stat o_stat,
    output i2cee_pkg::t_out     o_out
);
    import i2cee_pkg::*;

    localparam int unsigned AW = $clog2(MEM_BYTES);
    localparam logic [AW-1:0] PAGE_MASK = AW'(PAGE_BYTES - 1);

    logic [7:0]    r_mem [MEM_BYTES];
    logic [7:0]    r_mem_rd;
    logic          r_rd_in_image;
    logic [AW-1:0] r_clr_addr;
    logic          r_wr_en;
    t_phase        r_phase, n_phase;
    logic [AW-1:0] r_wa, n_wa;
    t_out          r_out, n_out;

    logic [15:0]   wa16;
    logic [AW-1:0] wa_page_inc;
    logic          in_image;
    logic          mem_wr;
    t_phase        wr_phase;

    assign wa16        = 16'(r_wa);
    assign wa_page_inc = (r_wa & ~PAGE_MASK) | ((r_wa + AW'(1)) & PAGE_MASK);
    assign in_image    = 32'(r_wa) < IMAGE_BYTES;
    assign wr_phase    = i_in.start_req ? PH_IDLE : r_phase;

    assign o_stat.clear_last   = (r_clr_addr == {AW{1'b1}});
    assign o_stat.needs_mem_rd = i_in.func && (r_phase == PH_ADDR_DONE);

    assign mem_wr = i_cmd.take_item && !i_in.func && (wr_phase == PH_ADDR_DONE)
                    && r_wr_en && in_image;

    always_comb begin
        n_phase = r_phase;
        n_wa    = r_wa;
        n_out   = r_out;
        if (i_cmd.load_mem_rd) begin
            n_out.read_data = r_rd_in_image ? r_mem_rd : ERASED_BYTE;
            n_out.ack       = 1'b0;
        end else if (i_cmd.take_item) begin
            n_out.read_data = 8'h00;
            n_out.ack       = 1'b0;
            if (i_in.func) begin
                unique case (r_phase)
                    PH_ADDR_DONE: n_wa = r_wa + AW'(1);
                    PH_ADDR_HI:   n_out.read_data = 8'h00;
                    default:      n_out.read_data = wa16[7:0];
                endcase
            end else begin
                unique case (wr_phase)
                    PH_ADDR_HI: begin
                        n_wa      = AW'({wa16[15:8], i_in.data});
                        n_phase   = PH_ADDR_DONE;
                        n_out.ack = r_wr_en;
                    end
                    PH_ADDR_DONE: begin
                        n_wa      = wa_page_inc;
                        n_out.ack = 1'b1;
                    end
                    default: begin
                        n_wa      = AW'({i_in.data, wa16[7:0]});
                        n_phase   = PH_ADDR_HI;
                        n_out.ack = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_wr_en    <= 1'b0;
            r_phase    <= PH_IDLE;
            r_wa       <= '0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_we) begin
                r_wr_en <= i_cfg_wdata;
            end
            r_phase <= n_phase;
            r_wa    <= n_wa;
        end
    end

    // Memory port: the erase pass and data writes share the write side.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            r_mem[r_clr_addr] <= ERASED_BYTE;
        end else if (mem_wr) begin
            r_mem[r_wa] <= i_in.data;
        end
        if (i_cmd.take_item) begin
            r_mem_rd      <= r_mem[r_wa];
            r_rd_in_image <= in_image;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out = r_out;

endmodule

[rtl/core/i2c_eeprom_slave_24cxx.sv]
// ----------------------------------------------------------------------------
// i2c_eeprom_slave_24cxx
// Byte-level 24Cxx-style I2C EEPROM slave: address phases, paged writes
// and sequential reads over an internal byte memory.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  in       | input     | i_in_valid / o_in_stall   | i_in  (func, start_req, data)
//  out      | output    | o_out_valid / i_out_stall | o_out (read_data, ack)
//  cfg      | input     | i_cfg_we                  | i_cfg_wdata (write_enable)
//
//  A read of stored data goes through the registered read port of the byte
//  memory and the ST_RDWAIT state; other beats load the result directly.
//  After reset the memory is erased one byte per cycle,
//  with o_in_stall high; configuration writes are taken during that time.
//  A new beat is accepted only in ST_RUN, while the result register is empty or drained.
// ----------------------------------------------------------------------------
module i2c_eeprom_slave_24cxx #(
    parameter int unsigned MEM_BYTES   = i2cee_pkg::MEM_BYTES_DEF,
    parameter int unsigned IMAGE_BYTES = i2cee_pkg::IMAGE_BYTES_DEF,
    parameter int unsigned PAGE_BYTES  = i2cee_pkg::PAGE_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  i2cee_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output i2cee_pkg::t_out o_out
);
    import i2cee_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    i2cee_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    i2cee_dp #(
        .MEM_BYTES   (MEM_BYTES),
        .IMAGE_BYTES (IMAGE_BYTES),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out       (o_out)
    );

endmodule

[rtl/core/i2cee_checker.sv]
// ----------------------------------------------------------------------------
// i2cee_checker
// Port-level checks for the EEPROM slave, bound to the top level.
// ----------------------------------------------------------------------------
module i2cee_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input i2cee_pkg::t_out o_out
);
    import i2cee_pkg::*;

    // The erase pass follows every reset, so no beat is taken right after it.
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input accepted right after reset");

    // A beat is never taken while an earlier result is still held back.
    a_no_accept_over_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> (!o_out_valid || !i_out_stall))
        else $error("input accepted while result is stalled");

    // An acknowledged beat is a write, which returns no data.
    a_ack_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.ack) |-> (o_out.read_data == 8'h00))
        else $error("acknowledged beat carries read data");

    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out))
        else $error("stalled result changed");

endmodule

bind i2c_eeprom_slave_24cxx i2cee_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
